// ===== hw/rtl/bmhq_pkg.sv =====
package bmhq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_LD,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic rd_root;
    logic rd_par;
    logic place;
    logic inc;
    logic up_cmp;
    logic ex_load;
    logic dn_cmp;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reject;
    logic is_ext;
    logic pos_zero;
    logic leaf;
    logic up_less;
    logic dn_move;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bmhq_dp.sv =====
module bmhq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmhq_pkg::in_item_t  in_data,
  input  bmhq_pkg::ctrl_cmd_t cmd,
  output bmhq_pkg::dp_stat_t  stat,
  output bmhq_pkg::out_item_t out_data
);
  import bmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = AW + 1;
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic [IW-1:0]           cnt_r;
  logic [IW-1:0]           pos_r;
  logic                    req_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] kout_r;
  logic [1:0]              stat_r;
  logic signed [KEY_W-1:0] rd_a_r;
  logic signed [KEY_W-1:0] rd_b_r;
  out_item_t               out_r;

  logic [IW-1:0]           parent;
  logic [IW-1:0]           lo_idx;
  logic [IW-1:0]           hi_idx;
  logic [AW-1:0]           rd_addr_a;
  logic [AW-1:0]           rd_addr_b;
  logic                    lo_take;
  logic                    hi_take;
  logic [IW-1:0]           best_idx;
  logic signed [KEY_W-1:0] best_val;
  logic                    up_less;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  assign parent = (pos_r - IW'(1)) >> 1;
  assign lo_idx = {pos_r[AW-1:0], 1'b1};
  assign hi_idx = lo_idx + IW'(1);

  // read port selection
  always_comb begin
    if (cmd.rd_root) begin
      rd_addr_a = '0;
      rd_addr_b = AW'(cnt_r - IW'(1));
    end else if (cmd.rd_par) begin
      rd_addr_a = parent[AW-1:0];
      rd_addr_b = hi_idx[AW-1:0];
    end else begin
      rd_addr_a = lo_idx[AW-1:0];
      rd_addr_b = hi_idx[AW-1:0];
    end
  end

  // pick the smaller child, left wins on a tie
  always_comb begin
    lo_take  = (lo_idx < cnt_r) && (rd_a_r < key_r);
    best_val = lo_take ? rd_a_r : key_r;
    best_idx = lo_take ? lo_idx : pos_r;
    hi_take  = (hi_idx < cnt_r) && (rd_b_r < best_val);
    if (hi_take) begin
      best_val = rd_b_r;
      best_idx = hi_idx;
    end
  end

  assign up_less = key_r < rd_a_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r[AW-1:0];
    wr_data = key_r;
    if (cmd.place) begin
      wr_en = 1'b1;
    end else if (cmd.up_cmp) begin
      wr_en   = 1'b1;
      wr_data = up_less ? rd_a_r : key_r;
    end else if (cmd.dn_cmp) begin
      wr_en   = 1'b1;
      wr_data = best_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ex_load) begin
      cnt_r <= cnt_r - IW'(1);
    end else if (cmd.inc || (cmd.up_cmp && !up_less)) begin
      cnt_r <= cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_data.req_type;
      key_r <= in_data.key_in;
      pos_r <= cnt_r;
      if (in_data.req_type == REQ_EXTRACT) begin
        stat_r <= (cnt_r == '0) ? ST_EMPTY : ST_OK;
        kout_r <= (cnt_r == '0) ? '1 : '0;
      end else begin
        stat_r <= (cnt_r == CAP_I) ? ST_FULL : ST_OK;
        kout_r <= '0;
      end
    end
    if (cmd.ex_load) begin
      kout_r <= rd_a_r;
      key_r  <= rd_b_r;
      pos_r  <= '0;
    end
    if (cmd.up_cmp && up_less) begin
      pos_r <= parent;
    end
    if (cmd.dn_cmp && (lo_take || hi_take)) begin
      pos_r <= best_idx;
    end
    if (cmd.load_out) begin
      out_r.key_out <= kout_r;
      out_r.status  <= stat_r;
      out_r.count   <= COUNT_W'(cnt_r);
    end
  end

  always_comb begin
    stat.reject   = (stat_r != ST_OK);
    stat.is_ext   = (req_r == REQ_EXTRACT);
    stat.pos_zero = (pos_r == '0);
    stat.leaf     = !(lo_idx < cnt_r);
    stat.up_less  = up_less;
    stat.dn_move  = lo_take || hi_take;
  end

  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_I)
    else $error("heap count above capacity");

  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (pos_r < CAP_I))
    else $error("heap write outside the store");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + IW'(1)) || (cnt_r == $past(cnt_r) - IW'(1))))
    else $error("heap count moved by more than one");
`endif

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
module bmhq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bmhq_pkg::dp_stat_t  stat,
  output bmhq_pkg::ctrl_cmd_t cmd
);
  import bmhq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.reject) begin
          state_nxt = S_RESP;
        end else if (stat.is_ext) begin
          cmd.rd_root = 1'b1;
          state_nxt   = S_EX_LD;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.place = 1'b1;
          cmd.inc   = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_par = 1'b1;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_nxt  = stat.up_less ? S_UP_RD : S_RESP;
      end
      S_EX_LD: begin
        cmd.ex_load = 1'b1;
        state_nxt   = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.leaf) begin
          cmd.place = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_nxt  = stat.dn_move ? S_DN_RD : S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_resp_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded without valid");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_DECIDE))
    else $error("request started outside idle");
`endif

endmodule

// ===== hw/rtl/binary_min_heap_queue_top.sv =====
// Bounded min-heap priority queue of signed 32-bit keys, CAPACITY deep. Each transaction
// either inserts a key or extracts the smallest one and returns one result with status,
// the extracted key and the count after the request. An accepted request first passes a
// decide state, from which a rejected or empty request goes straight to the response.
// An insert moves its key up level by level until it reaches the root or stops below its
// parent; an extract takes the root, moves the last entry to the root and sifts it down
// until it reaches a leaf or the last compare stops it. Each level passes a read state and
// a compare and write state over the heap memory, with both children read in the same
// cycle. One request is in flight at a time; the next one is taken the cycle after a
// result is loaded, even while that result still waits at the output register.
module binary_min_heap_queue_top #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmhq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmhq_pkg::out_item_t out_data
);
  import bmhq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
